// ----- rtl/tprs_pkg.sv -----
// shared types and constants for the tachometer rpm smoother
package tprs_pkg;

   // handshake status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } tprs_unit_status_type;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PERIOD         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSES_TO_AVERAGE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSES_PER_REV     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS_TIMEOUT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_INTERVAL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_INTERVAL   = 3'd5;

   // register widths
   localparam int MIN_PERIOD_W = 16;
   localparam int AVG_COUNT_W  = 4;
   localparam int PPR_W        = 8;
   localparam int LOSS_W       = 20;
   localparam int SMOOTH_W     = 16;
   localparam int DISPLAY_W    = 20;
   localparam int SILENCE_W    = 20;
   localparam int SHOWN_W      = 14;
   localparam int RPM_INT_W    = 20;
   localparam int GAIN_W       = 8;
   localparam int GAIN_SHIFT   = 8;

   // register reset values
   localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RESET = 16'd200;
   localparam logic [AVG_COUNT_W-1:0]  PULSES_AVG_RESET = 4'd4;
   localparam logic [PPR_W-1:0]        PPR_RESET        = 8'd2;
   localparam logic [LOSS_W-1:0]       LOSS_RESET       = 20'd300000;
   localparam logic [SMOOTH_W-1:0]     SMOOTH_RESET     = 16'd1000;
   localparam logic [DISPLAY_W-1:0]    DISPLAY_RESET    = 20'd50000;

   // microseconds per minute and the bits it needs
   localparam int RPM_SCALE   = 60000000;
   localparam int RPM_SCALE_W = 26;

   // smoothing gains in q0.8 and the gap limits in whole rpm
   localparam int GAP_HIGH_RPM = 1000;
   localparam int GAP_MID_RPM  = 300;
   localparam logic [GAIN_W-1:0] GAIN_HIGH = 8'd102;
   localparam logic [GAIN_W-1:0] GAIN_MID  = 8'd64;
   localparam logic [GAIN_W-1:0] GAIN_LOW  = 8'd26;

   localparam logic [SHOWN_W-1:0] SHOWN_MAX = 14'd9999;

endpackage

// ----- rtl/tprs_serial_mul.sv -----
// shift-and-add multiplier, one multiplier bit per cycle
module tprs_serial_mul import tprs_pkg::*; #(
   parameter int A_W = 32,
   parameter int B_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [A_W-1:0]       multiplicand,
   input  logic [B_W-1:0]       multiplier,
   output tprs_unit_status_type status,
   output logic [A_W+B_W-1:0]   product
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W);

   logic [P_W-1:0]   mcand_ff;
   logic [B_W-1:0]   mplier_ff;
   logic [P_W-1:0]   prod_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [P_W-1:0]   prod_in;

   assign prod_in = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mcand_ff  <= P_W'(multiplicand);
            mplier_ff <= multiplier;
            prod_ff   <= '0;
            cnt_ff    <= CNT_W'(B_W - 1);
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            prod_ff   <= prod_in;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = prod_ff;

endmodule

// ----- rtl/tprs_serial_div.sv -----
// restoring divider, one quotient bit per cycle
module tprs_serial_div import tprs_pkg::*; #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     numerator,
   input  logic [DEN_W-1:0]     denominator,
   output tprs_unit_status_type status,
   output logic [NUM_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_diff;
   logic             fits;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= numerator;
            den_ff  <= denominator;
            cnt_ff  <= CNT_W'(NUM_W - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- rtl/tachometer_period_rpm_smoother.sv -----
// top level: period tachometer with averaging, rpm division and adaptive smoothing
// sequence: an input transfer passes through the plan and finish states to a registered result; a smoothing
//   step adds a multiplier pass (eight multiplier bits plus start and hand-back), a pulses-per-rev write
//   adds one multiplier pass and one divider pass on the next tick,
//   and a new average period adds a second divider pass for the mean
// throughput: one item at a time, a new tick is taken only while idle; a stalled result
//   holds the block; reset: synchronous, tick state clears to zero, registers take defaults
module tachometer_period_rpm_smoother import tprs_pkg::*; #(
   parameter int PERIOD_BITS   = 32,
   parameter int RPM_FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // one microsecond tick per transfer
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_signal_level,
   // one result per tick
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SHOWN_W-1:0]     rsp_shown_rpm,
   output logic                   rsp_display_update,
   output logic                   rsp_signal_present
);

   // derived widths
   localparam int ACC_W     = PERIOD_BITS + AVG_COUNT_W;
   localparam int AVG_N_W   = AVG_COUNT_W + 1;
   localparam int RPM_W     = RPM_INT_W + RPM_FRAC_BITS;
   localparam int RPM_NUM_W = RPM_SCALE_W + RPM_FRAC_BITS;
   localparam int NUM_W     = (ACC_W > RPM_NUM_W) ? ACC_W : RPM_NUM_W;
   localparam int DEN_W     = PERIOD_BITS + PPR_W;
   localparam int MUL_A_W   = (PERIOD_BITS > RPM_W) ? PERIOD_BITS : RPM_W;
   localparam int PROD_W    = MUL_A_W + GAIN_W;

   localparam logic [NUM_W-1:0] RPM_NUMERATOR = NUM_W'(RPM_SCALE) << RPM_FRAC_BITS;
   localparam logic [RPM_W-1:0] GAP_HIGH      = RPM_W'(GAP_HIGH_RPM) << RPM_FRAC_BITS;
   localparam logic [RPM_W-1:0] GAP_MID       = RPM_W'(GAP_MID_RPM) << RPM_FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_DIV,
      ST_PLAN,
      ST_DEN_MUL,
      ST_RPM_DIV,
      ST_GAIN_MUL,
      ST_FINISH
   } state_type;

   // configuration registers
   logic [MIN_PERIOD_W-1:0] min_period_ff;
   logic [AVG_COUNT_W-1:0]  pulses_avg_ff;
   logic [PPR_W-1:0]        ppr_ff;
   logic [LOSS_W-1:0]       loss_timeout_ff;
   logic [SMOOTH_W-1:0]     smooth_int_ff;
   logic [DISPLAY_W-1:0]    display_int_ff;

   // tick state
   state_type               state_ff;
   logic                    prev_level_ff;
   logic [PERIOD_BITS-1:0]  edge_cnt_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [AVG_COUNT_W-1:0]  acc_count_ff;
   logic [PERIOD_BITS-1:0]  avg_ff;
   logic [RPM_W-1:0]        q_ff;
   logic                    q_valid_ff;
   logic [RPM_W-1:0]        current_ff;
   logic [SILENCE_W-1:0]    silence_ff;
   logic [SMOOTH_W-1:0]     smooth_tmr_ff;
   logic [DISPLAY_W-1:0]    disp_tmr_ff;
   logic [SHOWN_W-1:0]      shown_ff;
   logic                    lost_ff;
   logic                    smooth_fire_ff;
   logic                    disp_fire_ff;
   logic                    toward_up_ff;

   // serial unit operands
   logic                    div_start_ff;
   logic [NUM_W-1:0]        div_num_ff;
   logic [DEN_W-1:0]        div_den_ff;
   logic                    mul_start_ff;
   logic [MUL_A_W-1:0]      mul_a_ff;
   logic [GAIN_W-1:0]       mul_b_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [SHOWN_W-1:0]      rsp_shown_ff;
   logic                    rsp_update_ff;
   logic                    rsp_present_ff;

   tprs_unit_status_type    div_status;
   tprs_unit_status_type    mul_status;
   logic [NUM_W-1:0]        div_quotient;
   logic [PROD_W-1:0]       mul_product;

   // next values computed at the input transfer
   logic                    req_accept;
   logic                    falling;
   logic [PERIOD_BITS-1:0]  edge_cnt_in;
   logic                    period_ok;
   logic [ACC_W-1:0]        acc_in;
   logic [AVG_COUNT_W-1:0]  acc_count_in;
   logic                    avg_launch;
   logic [AVG_N_W-1:0]      avg_n;
   logic [SILENCE_W-1:0]    silence_in;
   logic [SMOOTH_W-1:0]     smooth_tmr_in;
   logic                    smooth_fire;
   logic [DISPLAY_W-1:0]    disp_tmr_in;
   logic                    disp_fire;

   // smoothing and display values
   logic [PPR_W-1:0]        ppr_eff;
   logic [RPM_W-1:0]        target;
   logic                    toward_up;
   logic [RPM_W-1:0]        gap;
   logic [GAIN_W-1:0]       gain;
   logic [RPM_W-1:0]        mag;
   logic [RPM_W-1:0]        q_clamped;
   logic [RPM_INT_W-1:0]    whole;
   logic [SHOWN_W-1:0]      shown_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      // edge counter saturates, then a falling edge reads it as the period
      edge_cnt_in  = (&edge_cnt_ff) ? edge_cnt_ff : edge_cnt_ff + 1'b1;
      falling      = prev_level_ff && !req_signal_level;
      period_ok    = edge_cnt_in > PERIOD_BITS'(min_period_ff);
      acc_in       = acc_ff + ACC_W'(edge_cnt_in);
      acc_count_in = acc_count_ff + 1'b1;
      // a wrapped count means sixteen periods collected
      avg_launch   = falling && period_ok &&
                     ((acc_count_in == '0) || (acc_count_in >= pulses_avg_ff));
      avg_n        = (acc_count_in == '0) ? (AVG_N_W'(1) << AVG_COUNT_W)
                                          : AVG_N_W'(acc_count_in);
      if (falling) begin
         silence_in = '0;
      end else if (&silence_ff) begin
         silence_in = silence_ff;
      end else begin
         silence_in = silence_ff + 1'b1;
      end
      // a zero interval fires on every tick
      smooth_tmr_in = smooth_tmr_ff + 1'b1;
      smooth_fire   = smooth_tmr_in >= smooth_int_ff;
      disp_tmr_in   = disp_tmr_ff + 1'b1;
      disp_fire     = disp_tmr_in >= display_int_ff;

      ppr_eff = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;

      // target is zero while the signal is lost or before the first average
      target    = (lost_ff || (avg_ff == '0)) ? '0 : q_ff;
      toward_up = target >= current_ff;
      gap       = toward_up ? target - current_ff : current_ff - target;
      if (gap > GAP_HIGH) begin
         gain = GAIN_HIGH;
      end else if (gap > GAP_MID) begin
         gain = GAIN_MID;
      end else begin
         gain = GAIN_LOW;
      end
      mag = mul_product[RPM_W+GAIN_SHIFT-1:GAIN_SHIFT];

      q_clamped = (|div_quotient[NUM_W-1:RPM_W]) ? '1 : div_quotient[RPM_W-1:0];

      whole    = current_ff[RPM_W-1:RPM_FRAC_BITS];
      shown_in = (whole > RPM_INT_W'(SHOWN_MAX)) ? SHOWN_MAX : whole[SHOWN_W-1:0];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff   <= MIN_PERIOD_RESET;
         pulses_avg_ff   <= PULSES_AVG_RESET;
         ppr_ff          <= PPR_RESET;
         loss_timeout_ff <= LOSS_RESET;
         smooth_int_ff   <= SMOOTH_RESET;
         display_int_ff  <= DISPLAY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_PERIOD:         min_period_ff   <= csr_data[MIN_PERIOD_W-1:0];
            CSR_PULSES_TO_AVERAGE:  pulses_avg_ff   <= csr_data[AVG_COUNT_W-1:0];
            CSR_PULSES_PER_REV:     ppr_ff          <= csr_data[PPR_W-1:0];
            CSR_LOSS_TIMEOUT:       loss_timeout_ff <= csr_data[LOSS_W-1:0];
            CSR_SMOOTHING_INTERVAL: smooth_int_ff   <= csr_data[SMOOTH_W-1:0];
            CSR_DISPLAY_INTERVAL:   display_int_ff  <= csr_data[DISPLAY_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_level_ff  <= 1'b0;
         edge_cnt_ff    <= '0;
         acc_ff         <= '0;
         acc_count_ff   <= '0;
         avg_ff         <= '0;
         q_valid_ff     <= 1'b0;
         current_ff     <= '0;
         silence_ff     <= '0;
         smooth_tmr_ff  <= '0;
         disp_tmr_ff    <= '0;
         shown_ff       <= '0;
         lost_ff        <= 1'b0;
         smooth_fire_ff <= 1'b0;
         disp_fire_ff   <= 1'b0;
         div_start_ff   <= 1'b0;
         mul_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  prev_level_ff  <= req_signal_level;
                  silence_ff     <= silence_in;
                  lost_ff        <= silence_in > SILENCE_W'(loss_timeout_ff);
                  smooth_tmr_ff  <= smooth_fire ? '0 : smooth_tmr_in;
                  smooth_fire_ff <= smooth_fire;
                  disp_tmr_ff    <= disp_fire ? '0 : disp_tmr_in;
                  disp_fire_ff   <= disp_fire;
                  edge_cnt_ff    <= falling ? '0 : edge_cnt_in;
                  // glitch periods still clear the counter but are not summed
                  if (falling && period_ok) begin
                     if (avg_launch) begin
                        acc_ff       <= '0;
                        acc_count_ff <= '0;
                     end else begin
                        acc_ff       <= acc_in;
                        acc_count_ff <= acc_count_in;
                     end
                  end
                  if (avg_launch) begin
                     div_num_ff   <= NUM_W'(acc_in);
                     div_den_ff   <= DEN_W'(avg_n);
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_AVG_DIV;
                  end else begin
                     state_ff <= ST_PLAN;
                  end
               end
            end
            ST_AVG_DIV: begin
               if (div_status.done) begin
                  avg_ff     <= div_quotient[PERIOD_BITS-1:0];
                  q_valid_ff <= 1'b0;
                  state_ff   <= ST_PLAN;
               end
            end
            ST_PLAN: begin
               // refresh the cached quotient first, then the smoothing step
               if (!q_valid_ff && (avg_ff != '0)) begin
                  mul_a_ff     <= MUL_A_W'(avg_ff);
                  mul_b_ff     <= ppr_eff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_DEN_MUL;
               end else if (smooth_fire_ff) begin
                  mul_a_ff     <= MUL_A_W'(gap);
                  mul_b_ff     <= gain;
                  toward_up_ff <= toward_up;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_GAIN_MUL;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_DEN_MUL: begin
               if (mul_status.done) begin
                  div_num_ff   <= RPM_NUMERATOR;
                  div_den_ff   <= mul_product[DEN_W-1:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_RPM_DIV;
               end
            end
            ST_RPM_DIV: begin
               if (div_status.done) begin
                  q_ff       <= q_clamped;
                  q_valid_ff <= 1'b1;
                  state_ff   <= ST_PLAN;
               end
            end
            ST_GAIN_MUL: begin
               // step is rounded down so the current value never overshoots
               if (mul_status.done) begin
                  current_ff <= toward_up_ff ? current_ff + mag : current_ff - mag;
                  state_ff   <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!(rsp_valid_ff && rsp_stall)) begin
                  if (disp_fire_ff) begin
                     shown_ff <= shown_in;
                  end
                  rsp_shown_ff   <= disp_fire_ff ? shown_in : shown_ff;
                  rsp_update_ff  <= disp_fire_ff;
                  rsp_present_ff <= !lost_ff;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // a new pulses-per-rev value invalidates the cached quotient
         if (csr_write && (csr_index == CSR_PULSES_PER_REV)) begin
            q_valid_ff <= 1'b0;
         end
      end
   end

   tprs_serial_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start_ff),
      .numerator   (div_num_ff),
      .denominator (div_den_ff),
      .status      (div_status),
      .quotient    (div_quotient)
   );

   tprs_serial_mul #(
      .A_W (MUL_A_W),
      .B_W (GAIN_W)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start_ff),
      .multiplicand (mul_a_ff),
      .multiplier   (mul_b_ff),
      .status       (mul_status),
      .product      (mul_product)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shown_rpm      = rsp_shown_ff;
   assign rsp_display_update = rsp_update_ff;
   assign rsp_signal_present = rsp_present_ff;

   // shown value stays within the display range
   a_shown_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shown_rpm <= SHOWN_MAX))
      else $error("shown rpm above display range");

   // a pulses-per-rev write forces the quotient to be recomputed
   a_ppr_invalidates: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_PULSES_PER_REV)) |=> !q_valid_ff)
      else $error("stale rpm quotient after pulses-per-rev write");

   // divider completes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> ((state_ff == ST_AVG_DIV) || (state_ff == ST_RPM_DIV)))
      else $error("divider finished outside a division state");

   // the two serial units never run together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_status.busy && mul_status.busy))
      else $error("divider and multiplier busy at once");

endmodule
